FILE: sv/gbit_pkg.sv
// Shared types and constants for the gas baseline IAQ tracker.
package gbit_pkg;
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_SEED   = 2'd1;
	localparam logic [1:0] REQ_CLOCK  = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;
	localparam logic [12:0] GAS_FULL    = 13'd7500;
	localparam logic [11:0] HUM_FULL    = 12'd2500;
	localparam logic [13:0] SCORE_TOTAL = 14'd10000;
	localparam logic [13:0] HUM_TOP     = 14'd10000;
	localparam logic [12:0] IAQ_MAX     = 13'd5000;
	localparam logic [31:0] AGE_DEFAULT = 32'd604800;
	localparam logic [13:0] OPT_DEFAULT = 14'd4000;
	localparam logic CFG_MAX_AGE = 1'b0;
	localparam logic CFG_HUM_OPT = 1'b1;

	typedef struct packed {
		logic clr;     // clear max, start scan
		logic step;    // advance scan one entry
		logic div_go;  // start division
		logic div_sel; // 0 gas, 1 humidity
		logic fin;     // form iaq
	} gbit_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} gbit_sts_t;
endpackage

FILE: sv/gas_baseline_iaq_tracker.sv
// Top level of the gas baseline IAQ tracker.
// One beat at a time; the window scan and, for samples only, two 48-step serial divisions set the pace.
// Output beat is held until taken; the next input beat can be accepted from the cycle after that.
// Reset clears the window (entry valid bits), counters, flags and loads register defaults.
module gas_baseline_iaq_tracker import gbit_pkg::*; #(
	parameter int WINDOW = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] gas_ohms,
	input  logic [13:0] humidity_centi,
	input  logic [31:0] seed_epoch,
	input  logic [31:0] now_epoch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [12:0] iaq_tenths,
	output logic [31:0] baseline,
	output logic        filling,
	output logic        discarded,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] max_age_q;
	logic [13:0] hum_opt_q;
	gbit_cmd_t   cmd;
	gbit_sts_t   sts;
	logic        load, is_sample;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= AGE_DEFAULT;
			hum_opt_q <= OPT_DEFAULT;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MAX_AGE) max_age_q <= cfg_data;
			else hum_opt_q <= cfg_data[13:0];
		end
	end

	gbit_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.is_sample, .sts, .cmd, .load
	);

	gbit_dp #(.WINDOW(WINDOW)) u_dp (
		.clk, .arst_n, .load, .req_type, .gas_ohms, .humidity_centi,
		.seed_epoch, .now_epoch, .max_age(max_age_q), .hum_opt(hum_opt_q),
		.cmd, .sts, .iaq_tenths, .baseline, .filling, .discarded, .is_sample
	);
endmodule

FILE: sv/gbit_div.sv
// Serial restoring divider, one quotient bit per cycle.
module gbit_div import gbit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic [47:0] quo,
	output logic        done
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

FILE: sv/gbit_dp.sv
// Datapath: window store, state registers, scan and score arithmetic.
module gbit_dp import gbit_pkg::*; #(
	parameter int WINDOW = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [1:0]  req_type,
	input  logic [31:0] gas_ohms,
	input  logic [13:0] humidity_centi,
	input  logic [31:0] seed_epoch,
	input  logic [31:0] now_epoch,
	input  logic [31:0] max_age,
	input  logic [13:0] hum_opt,
	input  gbit_cmd_t   cmd,
	output gbit_sts_t   sts,
	output logic [12:0] iaq_tenths,
	output logic [31:0] baseline,
	output logic        filling,
	output logic        discarded,
	output logic        is_sample
);
	localparam int AW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [CW-1:0] WFULL = CW'(WINDOW);

	logic [31:0]   mem [WINDOW];
	logic [WINDOW-1:0] vld_q;   // entry holds non-zero-reset data
	logic [CW-1:0] fill_q;
	logic [AW-1:0] wpos_q;
	logic          rest_q, agechk_q;
	logic [31:0]   repoch_q;
	logic [1:0]    req_q;
	logic [31:0]   gas_q;
	logic [13:0]   hum_q;
	logic [31:0]   max_q;
	logic [CW-1:0] sidx_q;
	logic [31:0]   rd_q;
	logic          rdv_q;
	logic          disc_q;
	logic [12:0]   g_q;
	logic [11:0]   h_q;
	logic [12:0]   iaq_q;
	logic [47:0]   dnum;
	logic [31:0]   dden;
	logic [47:0]   dquo;
	logic          ddone;
	logic [31:0]   gmin;
	logic          hzero;
	logic [14:0]   sum;

	// Seed fill is a sweep: write fill value on scan steps when seeding.
	logic          seeding_q;
	logic [31:0]   seedval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wpos_q   <= '0;
			rest_q   <= 1'b0;
			agechk_q <= 1'b0;
			repoch_q <= '0;
			vld_q    <= '0;
			disc_q   <= 1'b0;
			seeding_q <= 1'b0;
		end else if (load) begin
			disc_q    <= 1'b0;
			seeding_q <= 1'b0;
			case (req_type)
				REQ_SAMPLE: begin
					vld_q[wpos_q] <= 1'b1;
					wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + AW'(1);
					if (fill_q < WFULL) fill_q <= fill_q + CW'(1);
				end
				REQ_SEED: begin
					if (gas_ohms != 32'd0) begin
						vld_q     <= '1;
						fill_q    <= WFULL;
						wpos_q    <= '0;
						rest_q    <= 1'b1;
						repoch_q  <= seed_epoch;
						seeding_q <= 1'b1;
					end
				end
				REQ_CLOCK: begin
					if (now_epoch != 32'd0 && !agechk_q && rest_q) begin
						agechk_q <= 1'b1;
						if (repoch_q != 32'd0 && now_epoch >= repoch_q &&
							now_epoch - repoch_q > max_age) begin
							vld_q  <= '0;
							fill_q <= '0;
							wpos_q <= '0;
							rest_q <= 1'b0;
							disc_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q     <= req_type;
			gas_q     <= gas_ohms;
			hum_q     <= humidity_centi;
			seedval_q <= gas_ohms;
			if (req_type == REQ_SAMPLE) mem[wpos_q] <= gas_ohms;
		end else if (seeding_q && cmd.step && sidx_q < WFULL) begin
			mem[sidx_q[AW-1:0]] <= seedval_q;
		end
	end

	// scan: read one entry per step, registered read data
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			sidx_q <= '0;
			max_q  <= '0;
			rdv_q  <= 1'b0;
		end else if (cmd.step) begin
			if (sidx_q < WFULL) begin
				rd_q   <= seeding_q ? seedval_q : mem[sidx_q[AW-1:0]];
				rdv_q  <= (sidx_q < fill_q) && vld_q[sidx_q[AW-1:0]];
				sidx_q <= sidx_q + CW'(1);
			end else begin
				rdv_q <= 1'b0;
			end
			if (rdv_q && rd_q > max_q) max_q <= rd_q;
		end
	end
	assign sts.scan_done = (sidx_q == WFULL) && !rdv_q;

	assign gmin  = (gas_q > max_q) ? max_q : gas_q;
	assign hzero = hum_q >= HUM_TOP;
	always_comb begin
		if (!cmd.div_sel) begin
			dnum = 48'(gmin) * 48'(GAS_FULL);
			dden = max_q;
		end else if (hum_q >= hum_opt) begin
			dnum = 48'(HUM_TOP - hum_q) * 48'(HUM_FULL);
			dden = 32'(HUM_TOP - hum_opt);
		end else begin
			dnum = 48'(hum_q) * 48'(HUM_FULL);
			dden = 32'(hum_opt);
		end
	end

	gbit_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.num(dnum), .den(dden), .quo(dquo), .done(ddone)
	);
	assign sts.div_done = ddone;

	always_ff @(posedge clk) begin
		if (ddone) begin
			if (!cmd.div_sel) g_q <= dquo[12:0];
			else if (hzero && hum_q >= hum_opt) h_q <= '0;
			else h_q <= (dquo > 48'(HUM_FULL)) ? HUM_FULL : dquo[11:0];
		end
	end

	assign sum = 15'(g_q) + 15'(h_q);
	always_ff @(posedge clk) begin
		if (load) iaq_q <= '0;
		else if (cmd.fin) begin
			if (max_q == 32'd0 || sum >= 15'(SCORE_TOTAL)) iaq_q <= '0;
			else iaq_q <= 13'((15'(SCORE_TOTAL) - sum) >> 1);
		end
	end

	assign iaq_tenths = (iaq_q > IAQ_MAX) ? IAQ_MAX : iaq_q;
	assign baseline   = max_q;
	assign filling    = fill_q < WFULL;
	assign discarded  = disc_q;
	assign is_sample  = req_q == REQ_SAMPLE;
endmodule

FILE: sv/gbit_ctrl.sv
// Controller: sequences scan, divisions and result hand-off.
module gbit_ctrl import gbit_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      is_sample,
	input  gbit_sts_t sts,
	output gbit_cmd_t cmd,
	output logic      load
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DGAS, S_WGAS, S_DHUM, S_WHUM, S_FIN, S_OUT}
		state_t;
	state_t state_q;

	assign in_ready  = state_q == S_IDLE;
	assign load      = in_valid && in_ready;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd = '0;
		cmd.clr     = load;
		cmd.step    = state_q == S_SCAN;
		cmd.div_go  = state_q == S_DGAS || state_q == S_DHUM;
		cmd.div_sel = state_q == S_DHUM || state_q == S_WHUM;
		cmd.fin     = state_q == S_FIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else begin
			case (state_q)
				S_IDLE: if (load) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= is_sample ? S_DGAS : S_OUT;
				S_DGAS: state_q <= S_WGAS;
				S_WGAS: if (sts.div_done) state_q <= S_DHUM;
				S_DHUM: state_q <= S_WHUM;
				S_WHUM: if (sts.div_done) state_q <= S_FIN;
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output beat open together");
	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n) load |=> state_q == S_SCAN)
		else $error("accepted beat did not start scan");
	a_div_ok: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_WGAS || state_q == S_WHUM))
		else $error("division finished outside wait state");
endmodule
